### sv/least_loaded_replica_selector_macros.svh
// ----------------------------------------------------------------------------
// Least-loaded replica selector assertion macros
// Concurrent assertion helpers that sample on clock and are off during reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_REPLICA_SELECTOR_MACROS_SVH
`define LEAST_LOADED_REPLICA_SELECTOR_MACROS_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge out of reset.
`define LLRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define LLRS_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);
`else
`define LLRS_ASSERT(label, prop, msg)
`define LLRS_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

### sv/llrs_pkg.sv
// ----------------------------------------------------------------------------
// Least-loaded replica selector package
// Request and status codes, reset values and stream packing widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llrs_pkg;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_PICK   = 2'd2,
      REQ_UPDATE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_ALREADY     = 2'd1,
      ST_NOT_PRESENT = 2'd2,
      ST_EMPTY       = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam logic CSR_LOW_RATIO  = 1'b0;
   localparam logic CSR_HIGH_RATIO = 1'b1;

   localparam logic [7:0] LOW_RATIO_RESET  = 8'd80;
   localparam logic [7:0] HIGH_RATIO_RESET = 8'd105;
   localparam logic [6:0] PCT_SCALE        = 7'd100;

   localparam int REQ_DATA_BITS = 24;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 8;
   localparam int RSP_USER_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

endpackage

`default_nettype wire

### sv/least_loaded_replica_selector.sv
// ----------------------------------------------------------------------------
// Least-loaded replica selector
// Table of replica slots with loads; insert, remove, pick the least loaded
// slot, and update a load with advisories against the average load.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req_ stream (kind in tuser, slot and load in tdata);
// every request yields exactly one transfer on the rsp_ stream (status in
// tuser, chosen slot and advisories in tdata). The user must write the ratio
// registers through the csr_ port while the block is idle; it is not enforced.
// Loads sit in a memory with a registered read port; one request is
// processed at a time. Insert, remove and every refused request pass a
// lookup state; a load update adds the memory read, two multiply stages
// and a compare; a pick on an empty set goes straight to the result and any
// other pick runs a scan that reads every slot once. The block is ready for
// the next request as the result enters the output register.
// Reset (synchronous) clears all valid marks, the load total and the member
// count and restores the ratio registers to 80 and 105 percent; no clearing
// pass is needed. If rsp_tready is low, the result waits in the output
// register and the block holds the following result until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "least_loaded_replica_selector_macros.svh"

module least_loaded_replica_selector #(
   parameter int SLOTS     = 16,
   parameter int LOAD_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // slot_index [3:0], load_value [19:4], zero [23:20]
   input  wire logic [llrs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_type [1:0]
   input  wire logic [llrs_pkg::REQ_USER_BITS-1:0]  req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // chosen_slot [3:0], nominal_advisory [4], high_advisory [5], zero [7:6]
   output logic [llrs_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // status [1:0]
   output logic [llrs_pkg::RSP_USER_BITS-1:0]       rsp_tuser,
   input  wire logic                                csr_we,
   input  wire logic                                csr_index,
   input  wire logic [llrs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import llrs_pkg::*;

   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PTR_BITS   = $clog2(SLOTS + 1);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int TOTAL_BITS = LOAD_BITS + IDX_BITS;
   localparam int P1_BITS    = LOAD_BITS + 7;
   localparam int RHS_BITS   = TOTAL_BITS + 8;
   localparam int CMP_BITS   = LOAD_BITS + IDX_BITS + 16;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOOK = 7'b0000010,
      S_MUL1 = 7'b0000100,
      S_MUL2 = 7'b0001000,
      S_CMP  = 7'b0010000,
      S_SCAN = 7'b0100000,
      S_RESP = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   req_kind_type              kind_ff, kind_in;
   logic [IDX_BITS-1:0]       addr_ff, addr_in;
   logic                      range_ff, range_in;
   logic [LOAD_BITS-1:0]      load_ff, load_in;
   logic [SLOTS-1:0]          valid_ff, valid_in;
   logic [TOTAL_BITS-1:0]     total_ff, total_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [7:0]                low_ff, low_in;
   logic [7:0]                high_ff, high_in;
   logic [PTR_BITS-1:0]       ptr_ff, ptr_in;
   logic                      cmp_pend_ff, cmp_pend_in;
   logic                      cmp_live_ff, cmp_live_in;
   logic [IDX_BITS-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                      found_ff, found_in;
   logic [IDX_BITS-1:0]       best_ff, best_in;
   logic [LOAD_BITS-1:0]      best_load_ff, best_load_in;
   logic [P1_BITS-1:0]        lhs1_ff, lhs1_in;
   logic [RHS_BITS-1:0]       rhs_lo_ff, rhs_lo_in;
   logic [CMP_BITS-1:0]       lhs2_ff, lhs2_in;
   logic [RHS_BITS-1:0]       rhs_hi_ff, rhs_hi_in;
   status_type                res_status_ff, res_status_in;
   logic [3:0]                res_slot_ff, res_slot_in;
   logic                      res_nom_ff, res_nom_in;
   logic                      res_high_ff, res_high_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_BITS-1:0]  rsp_user_ff, rsp_user_in;

   // Load memory: one write and one registered read per cycle.
   logic [LOAD_BITS-1:0]      load_mem [SLOTS];
   logic [LOAD_BITS-1:0]      rd_data_ff;
   logic [IDX_BITS-1:0]       rd_addr;
   logic                      mem_we;

   logic                      req_fire;
   logic [31:0]               req_idx_wide;
   logic [31:0]               req_load_wide;
   logic [31:0]               best_wide;
   logic                      present;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign req_idx_wide  = 32'(req_tdata[3:0]);
   assign req_load_wide = 32'(req_tdata[19:4]);
   assign best_wide     = 32'(best_ff);
   assign present       = range_ff && valid_ff[addr_ff];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The request address feeds the read port on accept so the old load is
   // ready in S_LOOK; the scan owns the port while it runs.
   assign rd_addr = (state_ff == S_SCAN) ? ptr_ff[IDX_BITS-1:0]
                                         : req_idx_wide[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         load_mem[addr_ff] <= load_ff;
      end
      rd_data_ff <= load_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      range_in      = range_ff;
      load_in       = load_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      ptr_in        = ptr_ff;
      cmp_pend_in   = cmp_pend_ff;
      cmp_live_in   = cmp_live_ff;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      lhs1_in       = lhs1_ff;
      rhs_lo_in     = rhs_lo_ff;
      lhs2_in       = lhs2_ff;
      rhs_hi_in     = rhs_hi_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_nom_in    = res_nom_ff;
      res_high_in   = res_high_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_we        = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_RATIO:  low_in  = csr_wdata;
            CSR_HIGH_RATIO: high_in = csr_wdata;
            default:        low_in  = low_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in       = req_kind_type'(req_tuser);
               addr_in       = req_idx_wide[IDX_BITS-1:0];
               range_in      = (req_idx_wide < 32'(SLOTS));
               load_in       = req_load_wide[LOAD_BITS-1:0];
               res_status_in = ST_OK;
               res_slot_in   = 4'd0;
               res_nom_in    = 1'b0;
               res_high_in   = 1'b0;
               if (req_kind_type'(req_tuser) == REQ_PICK) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     ptr_in      = '0;
                     cmp_pend_in = 1'b0;
                     found_in    = 1'b0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_LOOK: begin
            state_in = S_RESP;
            if (!range_ff) begin
               res_status_in = ST_NOT_PRESENT;
            end else begin
               case (kind_ff)
                  REQ_INSERT: begin
                     if (present) begin
                        res_status_in = ST_ALREADY;
                     end else begin
                        mem_we            = 1'b1;
                        valid_in[addr_ff] = 1'b1;
                        total_in          = total_ff + TOTAL_BITS'(load_ff);
                        count_in          = count_ff + CNT_BITS'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (!present) begin
                        res_status_in = ST_NOT_PRESENT;
                     end else begin
                        valid_in[addr_ff] = 1'b0;
                        total_in          = total_ff - TOTAL_BITS'(rd_data_ff);
                        count_in          = count_ff - CNT_BITS'(1);
                     end
                  end
                  REQ_UPDATE: begin
                     if (!present) begin
                        res_status_in = ST_NOT_PRESENT;
                     end else begin
                        mem_we   = 1'b1;
                        total_in = total_ff - TOTAL_BITS'(rd_data_ff)
                                   + TOTAL_BITS'(load_ff);
                        state_in = S_MUL1;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         // The advisory tests compare load*100*count against ratio*total.
         S_MUL1: begin
            lhs1_in   = P1_BITS'(load_ff) * P1_BITS'(PCT_SCALE);
            rhs_lo_in = RHS_BITS'(low_ff) * RHS_BITS'(total_ff);
            state_in  = S_MUL2;
         end

         S_MUL2: begin
            lhs2_in   = CMP_BITS'(lhs1_ff) * CMP_BITS'(count_ff);
            rhs_hi_in = RHS_BITS'(high_ff) * RHS_BITS'(total_ff);
            state_in  = S_CMP;
         end

         S_CMP: begin
            if (total_ff != '0) begin
               res_nom_in  = (lhs2_ff < CMP_BITS'(rhs_lo_ff));
               res_high_in = (lhs2_ff > CMP_BITS'(rhs_hi_ff));
            end
            state_in = S_RESP;
         end

         // One slot is read per cycle; each slot is compared in the cycle after its read.
         S_SCAN: begin
            if (cmp_pend_ff && cmp_live_ff && (!found_ff || rd_data_ff < best_load_ff)) begin
               found_in     = 1'b1;
               best_in      = cmp_idx_ff;
               best_load_in = rd_data_ff;
            end
            if (ptr_ff < PTR_BITS'(SLOTS)) begin
               cmp_pend_in = 1'b1;
               cmp_idx_in  = ptr_ff[IDX_BITS-1:0];
               cmp_live_in = valid_ff[ptr_ff[IDX_BITS-1:0]];
               ptr_in      = ptr_ff + PTR_BITS'(1);
            end else begin
               cmp_pend_in = 1'b0;
               if (!cmp_pend_ff) begin
                  res_status_in = found_ff ? ST_OK : ST_EMPTY;
                  res_slot_in   = found_ff ? best_wide[3:0] : 4'd0;
                  state_in      = S_RESP;
               end
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_high_ff, res_nom_ff, res_slot_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         low_ff       <= LOW_RATIO_RESET;
         high_ff      <= HIGH_RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      range_ff      <= range_in;
      load_ff       <= load_in;
      ptr_ff        <= ptr_in;
      cmp_pend_ff   <= cmp_pend_in;
      cmp_live_ff   <= cmp_live_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_load_ff  <= best_load_in;
      lhs1_ff       <= lhs1_in;
      rhs_lo_ff     <= rhs_lo_in;
      lhs2_ff       <= lhs2_in;
      rhs_hi_ff     <= rhs_hi_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_nom_ff    <= res_nom_in;
      res_high_ff   <= res_high_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   `LLRS_ASSERT(a_count_matches_valid, ($countones(valid_ff) == 32'(count_ff)), "member count differs from valid marks")
   `LLRS_ASSERT(a_empty_total_zero, ((count_ff != '0) || (total_ff == '0)), "load total nonzero with no members")
   `LLRS_ASSERT_NEXT(a_one_request_at_a_time, req_fire, !req_tready, "request accepted while busy")

endmodule

`default_nettype wire

### dv/llrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded replica selector checker
// Watches the request, result and register ports, keeps its own copy of the
// replica table and ratio registers, predicts one result per accepted request
// and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------

module llrs_checker
   import llrs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   // slot_index [3:0], load_value [19:4], zero [23:20]
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // req_type [1:0]
   input  wire logic [REQ_USER_BITS-1:0]  req_tuser,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // chosen_slot [3:0], nominal_advisory [4], high_advisory [5], zero [7:6]
   input  wire logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // status [1:0]
   input  wire logic [RSP_USER_BITS-1:0]  rsp_tuser,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    pending_count,
   output int unsigned                    results_checked,
   output int unsigned                    advisories_seen
);

   localparam int TABLE_SLOTS = 16;

   typedef struct packed {
      status_type status;
      logic [3:0] slot;
      logic       nominal;
      logic       high;
   } selector_result_type;

   logic                member_valid [TABLE_SLOTS];
   logic [15:0]         member_load  [TABLE_SLOTS];
   logic [19:0]         load_sum;
   logic [4:0]          members;
   logic [7:0]          low_pct;
   logic [7:0]          high_pct;
   selector_result_type expected_results [$];
   int unsigned         mismatches = 0;
   int unsigned         checked_total = 0;
   int unsigned         advisory_total = 0;

   initial begin
      fail_count      = 0;
      pending_count   = 0;
      results_checked = 0;
      advisories_seen = 0;
   end

   // Applies one request to the shadow table and returns the result it causes.
   function automatic selector_result_type predict_selector_result(
      req_kind_type kind, logic [3:0] slot, logic [15:0] load);
      selector_result_type r;
      logic [63:0]         scaled_load;
      int                  best;
      r.status  = ST_OK;
      r.slot    = 4'd0;
      r.nominal = 1'b0;
      r.high    = 1'b0;
      case (kind)
         REQ_INSERT: begin
            if (member_valid[slot]) begin
               r.status = ST_ALREADY;
            end else begin
               member_valid[slot] = 1'b1;
               member_load[slot]  = load;
               load_sum           = load_sum + load;
               members            = members + 5'd1;
            end
         end
         REQ_REMOVE: begin
            if (!member_valid[slot]) begin
               r.status = ST_NOT_PRESENT;
            end else begin
               member_valid[slot] = 1'b0;
               load_sum           = load_sum - member_load[slot];
               member_load[slot]  = '0;
               members            = members - 5'd1;
            end
         end
         REQ_PICK: begin
            best = -1;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
               // Strict less-than keeps the lowest slot on a tie.
               if (member_valid[s] && (best < 0 || member_load[s] < member_load[best])) begin
                  best = s;
               end
            end
            if (members == 0 || best < 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.slot = best[3:0];
            end
         end
         default: begin
            if (!member_valid[slot]) begin
               r.status = ST_NOT_PRESENT;
            end else begin
               load_sum          = load_sum - member_load[slot] + load;
               member_load[slot] = load;
               // The average is compared by cross-multiplication, never divided.
               if (load_sum != 0 && members != 0) begin
                  scaled_load = 64'(load) * 64'(PCT_SCALE) * 64'(members);
                  r.nominal   = scaled_load < 64'(low_pct) * 64'(load_sum);
                  r.high      = scaled_load > 64'(high_pct) * 64'(load_sum);
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      selector_result_type want;
      logic                wrong;
      if (reset) begin
         for (int s = 0; s < TABLE_SLOTS; s++) begin
            member_valid[s] = 1'b0;
            member_load[s]  = '0;
         end
         load_sum = '0;
         members  = '0;
         low_pct  = LOW_RATIO_RESET;
         high_pct = HIGH_RATIO_RESET;
         expected_results.delete();
      end else begin
         // A result transfer always belongs to an older request, so it is
         // matched before the request of the same edge is predicted.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result with nothing expected: status=%0d tdata=%h",
                           $realtime, rsp_tuser, rsp_tdata);
               end
            end else begin
               want = expected_results.pop_front();
               checked_total++;
               if (rsp_tdata[4] === 1'b1 || rsp_tdata[5] === 1'b1) begin
                  advisory_total++;
               end
               wrong = (rsp_tuser !== want.status) || (rsp_tdata[3:0] !== want.slot) ||
                       (rsp_tdata[4] !== want.nominal) || (rsp_tdata[5] !== want.high) ||
                       (rsp_tdata[7:6] !== 2'b00);
               if (wrong) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"%0t: result mismatch: expected status=%0d slot=%0d nom=%0b ",
                               "high=%0b, got status=%0d slot=%0d nom=%0b high=%0b pad=%b"},
                              $realtime, want.status, want.slot, want.nominal, want.high,
                              rsp_tuser, rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[5],
                              rsp_tdata[7:6]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_selector_result(
               req_kind_type'(req_tuser), req_tdata[3:0], req_tdata[19:4]));
         end
         if (csr_we) begin
            if (csr_index == CSR_LOW_RATIO) begin
               low_pct = csr_wdata;
            end else begin
               high_pct = csr_wdata;
            end
         end
      end
      fail_count      <= mismatches;
      pending_count   <= expected_results.size();
      results_checked <= checked_total;
      advisories_seen <= advisory_total;
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded replica selector testbench
// Drives directed and random insert, remove, pick and load update requests
// under several ratio register settings, with random idle bursts on both
// streams and one long result stall; the checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
   import llrs_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int LONG_HOLD       = 400;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_USER_BITS-1:0] req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic                     csr_we     = 1'b0;
   logic                     csr_index  = CSR_LOW_RATIO;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned results_checked;
   int unsigned advisories_seen;
   int unsigned requests_sent  = 0;
   int unsigned settings_used  = 0;
   bit          req_idle_on      = 1'b1;
   bit          rsp_idle_on      = 1'b1;
   bit          rsp_hold_request = 1'b0;

   int low_setting  [PHASES] = '{80, 0, 255, 0, 255, 100, 0, 80};
   int high_setting [PHASES] = '{105, 0, 255, 255, 0, 100, 0, 105};

   always #5 clock = ~clock;

   least_loaded_replica_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   llrs_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .advisories_seen (advisories_seen)
   );

   // Offers one request and waits for its transfer. Valid stays high unless an
   // idle burst follows, so back-to-back requests never toggle it in one step.
   task automatic send_request(req_kind_type kind, logic [3:0] slot, logic [15:0] load);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, load, slot};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Mix of extremes, tiny values and a tight cluster that sits near the
   // average, where the advisory thresholds are decided.
   function automatic logic [15:0] random_load();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 15));
         3:       return 16'($urandom_range(1000, 1100));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_random_request();
      int unsigned  roll;
      req_kind_type kind;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         kind = REQ_INSERT;
      end else if (roll < 55) begin
         kind = REQ_REMOVE;
      end else if (roll < 75) begin
         kind = REQ_PICK;
      end else begin
         kind = REQ_UPDATE;
      end
      send_request(kind, 4'($urandom_range(0, 15)), random_load());
   endtask

   task automatic fill_table(bit full_scale);
      for (int s = 0; s < 16; s++) begin
         send_request(REQ_INSERT, 4'(s), full_scale ? 16'hFFFF : random_load());
      end
   endtask

   task automatic clear_table();
      for (int s = 0; s < 16; s++) begin
         send_request(REQ_REMOVE, 4'(s), random_load());
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Both ratio registers, written back to back while the block is idle.
   task automatic write_ratios(logic [7:0] low_pct, logic [7:0] high_pct);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOW_RATIO;
      csr_wdata <= low_pct;
      @(posedge clock);
      csr_index <= CSR_HIGH_RATIO;
      csr_wdata <= high_pct;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_directed();
      send_request(REQ_PICK,   4'd0,  16'h0000);   // empty set
      send_request(REQ_REMOVE, 4'd5,  16'hFFFF);   // remove of an absent slot
      send_request(REQ_UPDATE, 4'd5,  16'd1234);   // update of an absent slot
      send_request(REQ_INSERT, 4'd0,  16'h0000);
      send_request(REQ_UPDATE, 4'd0,  16'h0000);   // zero total, no advisory
      send_request(REQ_INSERT, 4'd0,  16'd77);     // already present
      send_request(REQ_INSERT, 4'd15, 16'hFFFF);
      send_request(REQ_INSERT, 4'd9,  16'h0000);
      send_request(REQ_PICK,   4'd0,  16'h0000);   // tie goes to the lowest slot
      send_request(REQ_UPDATE, 4'd15, 16'hFFFF);   // high advisory
      send_request(REQ_UPDATE, 4'd9,  16'h0001);   // nominal advisory
      send_request(REQ_INSERT, 4'd7,  16'h5555);
      send_request(REQ_INSERT, 4'd3,  16'hAAAA);
      send_request(REQ_PICK,   4'd0,  16'h0000);
      send_request(REQ_UPDATE, 4'd0,  16'hFFFF);
      send_request(REQ_PICK,   4'd0,  16'h0000);
      send_request(REQ_REMOVE, 4'd9,  16'h0000);
      send_request(REQ_REMOVE, 4'd9,  16'h0000);   // second remove finds nothing
      send_request(REQ_REMOVE, 4'd0,  16'h0000);
      send_request(REQ_REMOVE, 4'd3,  16'h0000);
      send_request(REQ_REMOVE, 4'd7,  16'h0000);
      send_request(REQ_REMOVE, 4'd15, 16'h0000);
      send_request(REQ_PICK,   4'd0,  16'h0000);   // empty again
      send_request(REQ_UPDATE, 4'd15, 16'h0000);   // update after removal
   endtask

   // Result side: random ready bursts, plus one long stall on request.
   initial begin
      int unsigned held;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
            rsp_hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned phase_target;
      logic [7:0]  low_pct;
      logic [7:0]  high_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain_results();
      for (int p = 0; p < PHASES; p++) begin
         // The first phase runs on the reset values of the ratio registers.
         if (p > 0) begin
            low_pct  = (p == 6) ? 8'($urandom_range(0, 255)) : 8'(low_setting[p]);
            high_pct = (p == 6) ? 8'($urandom_range(0, 255)) : 8'(high_setting[p]);
            write_ratios(low_pct, high_pct);
         end
         settings_used++;
         if (p == 2) begin
            rsp_hold_request = 1'b1;
         end
         if (p == PHASES - 1) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         phase_target = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_target) begin
            case ($urandom_range(0, 29))
               0: fill_table(1'b0);
               1: clear_table();
               2: begin
                  clear_table();
                  fill_table(1'b1);
               end
               default: send_random_request();
            endcase
         end
         drain_results();
      end
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests under %0d ratio settings; %0d results checked, %0d with an advisory.",
               requests_sent, settings_used, results_checked, advisories_seen);
      $display("Traffic included table fills and clears, a long result stall and a final phase without idling.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[least_loaded_replica_selector] OK");
      end else begin
         $display("[least_loaded_replica_selector] ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("[least_loaded_replica_selector] ERROR");
      $finish;
   end

endmodule
